@@ sv/assert_macros.svh @@
// Assertion macros used by the selector back stage (pcs_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property that is checked only while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Plain invariant that must hold at every clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ sv/pcs_pkg.sv @@
// Types, constants and widths shared by the perf CPU selector modules.
package pcs_pkg;

    localparam int NUM_CPUS    = 8;
    localparam int UTIL_BITS   = 11;
    localparam int NEWU_BITS   = UTIL_BITS + 1;
    localparam int LAT_BITS    = 16;
    localparam int CPU_BITS    = 3;
    localparam int CHOSEN_BITS = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_DEPTH   = 2;
    localparam int RPTR_BITS   = $clog2(RES_DEPTH);
    localparam int RCNT_BITS   = $clog2(RES_DEPTH + 1);

    localparam logic signed [CHOSEN_BITS-1:0] CPU_NONE = '1;

    typedef enum logic [1:0] {
        KIND_IDLE   = 2'd0,
        KIND_SPARE  = 2'd1,
        KIND_BACKUP = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // One classified candidate, as handed from the front to the back.
    typedef struct packed {
        logic                 take;
        logic [CPU_BITS-1:0]  cpu;
        logic                 is_idle;
        logic                 has_state;
        logic [LAT_BITS-1:0]  lat;
        logic [UTIL_BITS-1:0] cap_o;
        logic [UTIL_BITS-1:0] wake;
        logic [NEWU_BITS-1:0] load;
        logic [UTIL_BITS-1:0] spare;
        logic                 spare_ok;
        logic                 last;
    } t_cand;

    typedef struct packed {
        logic signed [CHOSEN_BITS-1:0] cpu;
        t_kind                         kind;
    } t_result;

endpackage

@@ sv/pcs_front.sv @@
// Front stage: accepts candidate words and precomputes utilization and spare capacity.
module pcs_front
    import pcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CPU_BITS-1:0]  i_cpu_index,
    input  logic                 i_eligible,
    input  logic                 i_over_utilized,
    input  logic                 i_is_idle,
    input  logic                 i_has_idle_state,
    input  logic [LAT_BITS-1:0]  i_exit_latency,
    input  logic [UTIL_BITS-1:0] i_capacity_original,
    input  logic [UTIL_BITS-1:0] i_capacity_current,
    input  logic [UTIL_BITS-1:0] i_wake_utilization,
    input  logic [UTIL_BITS-1:0] i_task_utilization,
    input  logic [UTIL_BITS-1:0] i_minimum_utilization,
    input  logic                 i_last_candidate,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_cand                o_cand
);

    logic                 r_valid;
    logic                 n_valid;
    t_cand                r_cand;
    t_cand                n_cand;
    logic                 accept;
    logic [NEWU_BITS-1:0] sum;
    logic [NEWU_BITS-1:0] floor_u;
    logic [NEWU_BITS-1:0] cand_load;
    logic [NEWU_BITS-1:0] cap_o_ext;

    assign full   = r_valid && !i_ready;
    assign accept = push && !full;

    always_comb begin
        sum       = {1'b0, i_wake_utilization} + {1'b0, i_task_utilization};
        floor_u   = {1'b0, i_minimum_utilization};
        cand_load = (sum < floor_u) ? floor_u : sum;
        cap_o_ext = {1'b0, i_capacity_original};

        n_cand.take      = i_eligible && !i_over_utilized
                           && (int'(i_cpu_index) < NUM_CPUS);
        n_cand.cpu       = i_cpu_index;
        n_cand.is_idle   = i_is_idle;
        n_cand.has_state = i_has_idle_state;
        n_cand.lat       = i_exit_latency;
        n_cand.cap_o     = i_capacity_original;
        n_cand.wake      = i_wake_utilization;
        n_cand.load      = cand_load;
        // Spare capacity saturates at zero rather than wrapping.
        n_cand.spare     = (cap_o_ext > cand_load) ? UTIL_BITS'(cap_o_ext - cand_load) : '0;
        n_cand.spare_ok  = {1'b0, i_capacity_current} > cand_load;
        n_cand.last      = i_last_candidate;

        n_valid = accept || (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cand <= n_cand;
        end
    end

    assign o_valid = r_valid;
    assign o_cand  = r_cand;

endmodule

@@ sv/pcs_queue.sv @@
// Short queue of classified candidates between the front and the back.
module pcs_queue
    import pcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cand i_cand,
    output logic  o_valid,
    input  logic  i_ready,
    output t_cand o_cand
);

    t_cand                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] n_count;
    logic                 wr_en;
    logic                 rd_en;

    assign o_ready = r_count != QCNT_BITS'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cand  = r_mem[r_rd_ptr];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cand;
        end
    end

endmodule

@@ sv/pcs_back.sv @@
// Back stage: keeps the running bests, picks the CPU on the last word and queues the result.
`include "assert_macros.svh"

module pcs_back
    import pcs_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_cand                         i_cand,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [CHOSEN_BITS-1:0] o_chosen_cpu,
    output logic [1:0]                    o_choice_kind
);

    // Running bests. A select flag set means the matching CPU number is held.
    logic [UTIL_BITS-1:0] r_idle_cap,    n_idle_cap;
    logic [UTIL_BITS-1:0] r_idle_util,   n_idle_util;
    logic [LAT_BITS-1:0]  r_idle_lat,    n_idle_lat;
    logic                 r_idle_valid,  n_idle_valid;
    logic                 r_idle_sel,    n_idle_sel;
    logic [CPU_BITS-1:0]  r_idle_cpu,    n_idle_cpu;
    logic [UTIL_BITS-1:0] r_spare,       n_spare;
    logic                 r_spare_sel,   n_spare_sel;
    logic [CPU_BITS-1:0]  r_spare_cpu,   n_spare_cpu;
    logic [UTIL_BITS-1:0] r_bk_wake,     n_bk_wake;
    logic [NEWU_BITS-1:0] r_bk_newu,     n_bk_newu;
    logic                 r_bk_sel,      n_bk_sel;
    logic [CPU_BITS-1:0]  r_bk_cpu,      n_bk_cpu;

    t_result              r_res [RES_DEPTH];
    logic [RPTR_BITS-1:0] r_res_wr,    n_res_wr;
    logic [RPTR_BITS-1:0] r_res_rd,    n_res_rd;
    logic [RCNT_BITS-1:0] r_res_count, n_res_count;

    logic    consume;
    logic    res_push;
    logic    res_pop;
    logic    res_room;
    logic    idle_loses;
    t_result result;

    assign res_room = r_res_count != RCNT_BITS'(RES_DEPTH);
    // Only a last candidate needs room in the result queue.
    assign o_ready  = !i_cand.last || res_room;
    assign consume  = i_valid && o_ready;
    assign res_push = consume && i_cand.last;
    assign res_pop  = pop && !empty;

    always_comb begin
        n_idle_cap   = r_idle_cap;
        n_idle_util  = r_idle_util;
        n_idle_lat   = r_idle_lat;
        n_idle_valid = r_idle_valid;
        n_idle_sel   = r_idle_sel;
        n_idle_cpu   = r_idle_cpu;
        n_spare      = r_spare;
        n_spare_sel  = r_spare_sel;
        n_spare_cpu  = r_spare_cpu;
        n_bk_wake    = r_bk_wake;
        n_bk_newu    = r_bk_newu;
        n_bk_sel     = r_bk_sel;
        n_bk_cpu     = r_bk_cpu;
        result       = '{cpu: CPU_NONE, kind: KIND_NONE};

        idle_loses = r_idle_valid && (i_cand.cap_o == r_idle_cap)
                     && ((i_cand.lat > r_idle_lat)
                         || ((i_cand.lat == r_idle_lat) && (i_cand.wake >= r_idle_util)));

        if (consume && i_cand.take) begin
            if (i_cand.is_idle) begin
                if (i_cand.cap_o >= r_idle_cap) begin
                    if (!i_cand.has_state) begin
                        // Taken as the pick, but its figures do not enter the record.
                        n_idle_sel = 1'b1;
                        n_idle_cpu = i_cand.cpu;
                    end else if (!idle_loses) begin
                        n_idle_cap   = i_cand.cap_o;
                        n_idle_util  = i_cand.wake;
                        n_idle_lat   = i_cand.lat;
                        n_idle_valid = 1'b1;
                        n_idle_sel   = 1'b1;
                        n_idle_cpu   = i_cand.cpu;
                    end
                end
            end else if (!r_idle_sel) begin
                if (i_cand.spare_ok && (i_cand.spare > r_spare)) begin
                    n_spare     = i_cand.spare;
                    n_spare_sel = 1'b1;
                    n_spare_cpu = i_cand.cpu;
                end else if (!r_bk_sel || !((i_cand.wake > r_bk_wake)
                                            || (i_cand.load > r_bk_newu))) begin
                    n_bk_wake = i_cand.wake;
                    n_bk_newu = i_cand.load;
                    n_bk_sel  = 1'b1;
                    n_bk_cpu  = i_cand.cpu;
                end
            end
        end

        if (n_idle_sel) begin
            result = '{cpu: {1'b0, n_idle_cpu}, kind: KIND_IDLE};
        end else if (n_spare_sel) begin
            result = '{cpu: {1'b0, n_spare_cpu}, kind: KIND_SPARE};
        end else if (n_bk_sel) begin
            result = '{cpu: {1'b0, n_bk_cpu}, kind: KIND_BACKUP};
        end

        // The pass ends here: all records return to their empty values.
        if (res_push) begin
            n_idle_cap   = '0;
            n_idle_util  = '1;
            n_idle_lat   = '1;
            n_idle_valid = 1'b0;
            n_idle_sel   = 1'b0;
            n_spare      = '0;
            n_spare_sel  = 1'b0;
            n_bk_wake    = '1;
            n_bk_newu    = '1;
            n_bk_sel     = 1'b0;
        end

        n_res_wr    = r_res_wr;
        n_res_rd    = r_res_rd;
        n_res_count = r_res_count;
        if (res_push) begin
            n_res_wr = (r_res_wr == RPTR_BITS'(RES_DEPTH - 1)) ? '0 : r_res_wr + 1'b1;
        end
        if (res_pop) begin
            n_res_rd = (r_res_rd == RPTR_BITS'(RES_DEPTH - 1)) ? '0 : r_res_rd + 1'b1;
        end
        if (res_push && !res_pop) begin
            n_res_count = r_res_count + 1'b1;
        end else if (res_pop && !res_push) begin
            n_res_count = r_res_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_cap   <= '0;
            r_idle_util  <= '1;
            r_idle_lat   <= '1;
            r_idle_valid <= 1'b0;
            r_idle_sel   <= 1'b0;
            r_spare      <= '0;
            r_spare_sel  <= 1'b0;
            r_bk_wake    <= '1;
            r_bk_newu    <= '1;
            r_bk_sel     <= 1'b0;
            r_res_wr     <= '0;
            r_res_rd     <= '0;
            r_res_count  <= '0;
        end else begin
            r_idle_cap   <= n_idle_cap;
            r_idle_util  <= n_idle_util;
            r_idle_lat   <= n_idle_lat;
            r_idle_valid <= n_idle_valid;
            r_idle_sel   <= n_idle_sel;
            r_spare      <= n_spare;
            r_spare_sel  <= n_spare_sel;
            r_bk_wake    <= n_bk_wake;
            r_bk_newu    <= n_bk_newu;
            r_bk_sel     <= n_bk_sel;
            r_res_wr     <= n_res_wr;
            r_res_rd     <= n_res_rd;
            r_res_count  <= n_res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idle_cpu  <= n_idle_cpu;
        r_spare_cpu <= n_spare_cpu;
        r_bk_cpu    <= n_bk_cpu;
        if (res_push) begin
            r_res[r_res_wr] <= result;
        end
    end

    assign empty         = r_res_count == '0;
    assign o_chosen_cpu  = r_res[r_res_rd].cpu;
    assign o_choice_kind = r_res[r_res_rd].kind;

    `ASSERT_NEVER(a_res_overflow, i_clk, i_rst_n, r_res_count > RCNT_BITS'(RES_DEPTH), "result queue overflow")
    `ASSERT_CLK(a_pass_clears, i_clk, i_rst_n, res_push |=> (!r_idle_sel && !r_spare_sel && !r_bk_sel && !r_idle_valid), "records not cleared after last candidate")
    `ASSERT_CLK(a_none_is_minus_one, i_clk, i_rst_n, (!empty && (r_res[r_res_rd].kind == KIND_NONE)) |-> (r_res[r_res_rd].cpu == CPU_NONE), "empty choice without cpu minus one")
    `ASSERT_CLK(a_push_grows, i_clk, i_rst_n, (res_push && !res_pop) |=> (r_res_count == $past(r_res_count) + 1'b1), "result word lost")

endmodule

@@ sv/perf_cpu_selector_unit.sv @@
// Perf CPU selector: accepts one candidate word per cycle while full is low and,
// after the word marked last, returns the chosen CPU and its kind. Candidates
// stream in at one word per clock until back-pressure raises full; the only loop
// is the update of the running bests in the back stage. A result reaches the
// output ports through the front register, the candidate queue and then the
// result queue, and up to two results may wait while new candidates keep
// arriving.
module perf_cpu_selector_unit
    import pcs_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [CPU_BITS-1:0]           i_cpu_index,
    input  logic                          i_eligible,
    input  logic                          i_over_utilized,
    input  logic                          i_is_idle,
    input  logic                          i_has_idle_state,
    input  logic [LAT_BITS-1:0]           i_exit_latency,
    input  logic [UTIL_BITS-1:0]          i_capacity_original,
    input  logic [UTIL_BITS-1:0]          i_capacity_current,
    input  logic [UTIL_BITS-1:0]          i_wake_utilization,
    input  logic [UTIL_BITS-1:0]          i_task_utilization,
    input  logic [UTIL_BITS-1:0]          i_minimum_utilization,
    input  logic                          i_last_candidate,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [CHOSEN_BITS-1:0] o_chosen_cpu,
    output logic [1:0]                    o_choice_kind
);

    logic  front_valid;
    logic  front_ready;
    t_cand front_cand;
    logic  back_valid;
    logic  back_ready;
    t_cand back_cand;

    pcs_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .push                  (push),
        .full                  (full),
        .i_cpu_index           (i_cpu_index),
        .i_eligible            (i_eligible),
        .i_over_utilized       (i_over_utilized),
        .i_is_idle             (i_is_idle),
        .i_has_idle_state      (i_has_idle_state),
        .i_exit_latency        (i_exit_latency),
        .i_capacity_original   (i_capacity_original),
        .i_capacity_current    (i_capacity_current),
        .i_wake_utilization    (i_wake_utilization),
        .i_task_utilization    (i_task_utilization),
        .i_minimum_utilization (i_minimum_utilization),
        .i_last_candidate      (i_last_candidate),
        .o_valid               (front_valid),
        .i_ready               (front_ready),
        .o_cand                (front_cand)
    );

    pcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cand  (front_cand),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_cand  (back_cand)
    );

    pcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (back_valid),
        .o_ready       (back_ready),
        .i_cand        (back_cand),
        .empty         (empty),
        .pop           (pop),
        .o_chosen_cpu  (o_chosen_cpu),
        .o_choice_kind (o_choice_kind)
    );

endmodule
